@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of the ring buffer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clk edge, switched off while arst_n is low
`define BRB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ring buffer check failed");

// Check on every rising clk edge, reset included
`define BRB_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("ring buffer check failed around reset");

`endif

@@ design/brb_pkg.sv @@
// Shared constants, codes and types of the burst ring buffer
package brb_pkg;

	localparam int RING_DEPTH = 4096;
	localparam int MAX_BURST  = 64;

	localparam int IDX_W    = $clog2(RING_DEPTH);
	localparam int CNT_W    = IDX_W + 1;
	localparam int CAP_W    = 13;
	localparam int BURST_W  = 7;
	localparam int DATA_W   = 8;
	localparam int STATUS_W = 3;
	localparam int OP_W     = 2;
	localparam int WIDE_W   = ((CNT_W > BURST_W) ? CNT_W : BURST_W) + 2;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int OUT_DEPTH  = 4;
	localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
	localparam int OUT_OCC_W  = OUT_PTR_W + 1;

	localparam logic [OP_W-1:0] OP_HDR  = 2'd0;
	localparam logic [OP_W-1:0] OP_DATA = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_HALF   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOROOM = 3'd2;
	localparam logic [STATUS_W-1:0] ST_SHORT  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;

	// Command from the front to the back: a single status result or a read run
	typedef struct packed {
		logic                is_run;
		logic [STATUS_W-1:0] status;
		logic                flush;
		logic [BURST_W-1:0]  count;
	} cmd_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [DATA_W-1:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0]   data;
		logic                valid;
		logic                last;
	} res_t;

endpackage

@@ design/brb_ram.sv @@
// Generic simple dual-port RAM with registered read
module brb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/brb_cmdq.sv @@
// Short command queue between the front and the back
module brb_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  brb_pkg::cmd_t din,
	output logic          full,
	input  logic          pop,
	output brb_pkg::cmd_t dout,
	output logic          empty
);

	localparam int PtrW = brb_pkg::CMDQ_PTR_W;

	brb_pkg::cmd_t    slot_q [brb_pkg::CMDQ_DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [PtrW:0]    occ_q;

	assign full  = (occ_q == (PtrW + 1)'(brb_pkg::CMDQ_DEPTH));
	assign empty = (occ_q == '0);
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				occ_q <= occ_q + (PtrW + 1)'(1);
			end else if (pop && !push) begin
				occ_q <= occ_q - (PtrW + 1)'(1);
			end
		end
	end

endmodule

@@ design/brb_front.sv @@
// Front: accepts items, keeps fill and burst bookkeeping, stores bytes, issues commands
module brb_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [brb_pkg::OP_W-1:0]        opcode,
	input  logic [brb_pkg::BURST_W-1:0]     burst_count,
	input  logic [brb_pkg::DATA_W-1:0]      data_in,
	input  logic                            flush_on_short,
	input  logic                            cfg_we,
	input  logic [brb_pkg::CAP_W-1:0]       cfg_wdata,
	output logic [brb_pkg::CNT_W-1:0]       cap,
	output brb_pkg::mem_wr_t                mem_wr,
	output logic                            cmd_push,
	output brb_pkg::cmd_t                   cmd,
	input  logic                            cmdq_full,
	input  logic                            rd_beat
);

	localparam int IdxW   = brb_pkg::IDX_W;
	localparam int CntW   = brb_pkg::CNT_W;
	localparam int BurstW = brb_pkg::BURST_W;
	localparam int WideW  = brb_pkg::WIDE_W;

	logic [CntW-1:0]   cap_q;
	logic [IdxW-1:0]   wr_idx_q;
	logic [CntW-1:0]   fill_q;
	logic [BurstW-1:0] left_q;
	logic              admit_q;
	logic [CntW-1:0]   pending_q;

	logic [BurstW-1:0] cnt;
	logic [WideW-1:0]  fill_w;
	logic [WideW-1:0]  cap_w;
	logic [WideW-1:0]  cnt_w;
	logic [WideW-1:0]  free_w;
	logic [WideW-1:0]  pend_w;
	logic              fits;
	logic              half;
	logic              enough;
	logic              store_open;
	logic [CntW-1:0]   wr_inc;
	logic [IdxW-1:0]   wr_next;
	logic              accept;
	logic              run_push;
	logic [CntW-1:0]   cap_new;

	assign cap = cap_q;

	always_comb begin
		cnt = (burst_count > BurstW'(brb_pkg::MAX_BURST)) ?
			BurstW'(brb_pkg::MAX_BURST) : burst_count;
		fill_w = WideW'(fill_q);
		cap_w  = WideW'(cap_q);
		cnt_w  = WideW'(cnt);
		free_w = (fill_w >= cap_w) ? '0 : cap_w - fill_w;
		fits   = (free_w >= cnt_w);
		half   = (((fill_w + cnt_w) << 1) > cap_w);
		enough = (fill_w >= cnt_w);
		// a data byte now would land in the ring
		store_open = (left_q != '0) && admit_q && (fill_q < cap_q);
		wr_inc  = {1'b0, wr_idx_q} + CntW'(1);
		wr_next = (wr_inc >= cap_q) ? '0 : wr_inc[IdxW-1:0];
		// hold stored bytes back while read bytes still wait in the ring
		full   = cmdq_full || ((pending_q != '0) && store_open);
		accept = push && !full;
		run_push = accept && (opcode == brb_pkg::OP_READ) && enough && (cnt != '0);
		pend_w = WideW'(pending_q) + (run_push ? cnt_w : '0) - WideW'(rd_beat);

		if (cfg_wdata == '0) begin
			cap_new = CntW'(1);
		end else if (32'(cfg_wdata) > brb_pkg::RING_DEPTH) begin
			cap_new = CntW'(brb_pkg::RING_DEPTH);
		end else begin
			cap_new = CntW'(cfg_wdata);
		end

		mem_wr.en   = accept && (opcode == brb_pkg::OP_DATA) && store_open;
		mem_wr.addr = wr_idx_q;
		mem_wr.data = data_in;

		cmd_push = accept && ((opcode == brb_pkg::OP_HDR) || (opcode == brb_pkg::OP_READ));
		cmd      = '0;
		case (opcode)
			brb_pkg::OP_HDR: begin
				cmd.status = fits ? (half ? brb_pkg::ST_HALF : brb_pkg::ST_OK) :
					brb_pkg::ST_NOROOM;
			end
			brb_pkg::OP_READ: begin
				if (enough) begin
					cmd.status = brb_pkg::ST_OK;
					cmd.is_run = (cnt != '0);
					cmd.count  = cnt;
				end else begin
					cmd.status = (fill_q == '0) ? brb_pkg::ST_EMPTY : brb_pkg::ST_SHORT;
					cmd.flush  = flush_on_short;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= CntW'(brb_pkg::RING_DEPTH);
			wr_idx_q  <= '0;
			fill_q    <= '0;
			left_q    <= '0;
			admit_q   <= 1'b0;
			pending_q <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cap_new;
			end
			pending_q <= pend_w[CntW-1:0];
			if (accept) begin
				case (opcode)
					brb_pkg::OP_HDR: begin
						left_q  <= cnt;
						admit_q <= fits;
					end
					brb_pkg::OP_DATA: begin
						if (left_q != '0) begin
							if (store_open) begin
								wr_idx_q <= wr_next;
								fill_q   <= fill_q + CntW'(1);
							end
							left_q <= left_q - BurstW'(1);
						end
					end
					brb_pkg::OP_READ: begin
						if (enough) begin
							fill_q <= fill_q - CntW'(cnt);
						end else if (flush_on_short) begin
							fill_q   <= '0;
							wr_idx_q <= '0;
						end
					end
					default: begin
						fill_q <= fill_q;
					end
				endcase
			end
		end
	end

endmodule

@@ design/brb_back.sv @@
// Back: runs commands, reads bytes from the ring and queues results
module brb_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [brb_pkg::CNT_W-1:0]   cap,
	input  brb_pkg::cmd_t               head,
	input  logic                        head_valid,
	output logic                        head_pop,
	output logic                        ram_re,
	output logic [brb_pkg::IDX_W-1:0]   ram_raddr,
	input  logic [brb_pkg::DATA_W-1:0]  ram_rdata,
	output logic                        empty,
	input  logic                        pop,
	output logic [brb_pkg::STATUS_W-1:0] status,
	output logic [brb_pkg::DATA_W-1:0]  data_out,
	output logic                        data_valid,
	output logic                        last
);

	localparam int IdxW   = brb_pkg::IDX_W;
	localparam int CntW   = brb_pkg::CNT_W;
	localparam int BurstW = brb_pkg::BURST_W;
	localparam int PtrW   = brb_pkg::OUT_PTR_W;
	localparam int OccW   = brb_pkg::OUT_OCC_W;

	logic [IdxW-1:0]             rd_idx_q;
	logic [BurstW-1:0]           done_q;
	logic                        s1_valid_q;
	logic                        s1_data_s1;
	logic [brb_pkg::STATUS_W-1:0] s1_status_s1;
	logic                        s1_last_s1;
	brb_pkg::res_t               out_q [brb_pkg::OUT_DEPTH];
	logic [PtrW-1:0]             wr_ptr_q;
	logic [PtrW-1:0]             rd_ptr_q;
	logic [OccW-1:0]             occ_q;

	logic [CntW-1:0]   rd_inc;
	logic [IdxW-1:0]   rd_next;
	logic [BurstW-1:0] done_inc;
	logic              run_last;
	logic              credit;
	logic              fire;
	logic              out_pop;
	brb_pkg::res_t     res_in;

	always_comb begin
		rd_inc   = {1'b0, rd_idx_q} + CntW'(1);
		rd_next  = (rd_inc >= cap) ? '0 : rd_inc[IdxW-1:0];
		done_inc = done_q + BurstW'(1);
		run_last = (done_inc == head.count);
		// count the beat in flight so the result queue never overflows
		credit   = ((occ_q + OccW'(s1_valid_q)) < OccW'(brb_pkg::OUT_DEPTH));
		fire     = head_valid && credit;
		head_pop = fire && (!head.is_run || run_last);
		ram_re   = fire && head.is_run;
		ram_raddr = rd_idx_q;
		out_pop  = pop && !empty;

		res_in.status = s1_status_s1;
		res_in.data   = s1_data_s1 ? ram_rdata : '0;
		res_in.valid  = s1_data_s1;
		res_in.last   = s1_last_s1;
	end

	assign empty      = (occ_q == '0);
	assign status     = out_q[rd_ptr_q].status;
	assign data_out   = out_q[rd_ptr_q].data;
	assign data_valid = out_q[rd_ptr_q].valid;
	assign last       = out_q[rd_ptr_q].last;

	always_ff @(posedge clk) begin
		if (fire) begin
			s1_data_s1   <= head.is_run;
			s1_status_s1 <= head.status;
			s1_last_s1   <= !head.is_run || run_last;
		end
		if (s1_valid_q) begin
			out_q[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q   <= '0;
			done_q     <= '0;
			s1_valid_q <= 1'b0;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			occ_q      <= '0;
		end else begin
			s1_valid_q <= fire;
			if (fire) begin
				if (head.is_run) begin
					rd_idx_q <= rd_next;
					done_q   <= run_last ? '0 : done_inc;
				end else if (head.flush) begin
					rd_idx_q <= '0;
				end
			end
			if (s1_valid_q) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (out_pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			if (s1_valid_q && !out_pop) begin
				occ_q <= occ_q + OccW'(1);
			end else if (out_pop && !s1_valid_q) begin
				occ_q <= occ_q - OccW'(1);
			end
		end
	end

endmodule

@@ design/burst_ring_buffer.sv @@
// Top level of the burst ring buffer: front, command queue, back and byte store
//
// Channel   Direction  Handshake          Beat
// items     in         push / full        opcode, burst_count, data_in, flush_on_short
// results   out        empty / pop        status, data_out, data_valid, last
// config    in         cfg_we             cfg_wdata (capacity in use)
//
// Items are taken at up to one per cycle; a read of n bytes gives n results at one a cycle
// if not stalled, paced by the single read port of the byte store. Results pass the
// command queue, read stage and result queue. Reset clears pointers, counts and burst
// state at once; the byte store is not cleared. full rises while the command queue is
// full, or while a byte of an admitted burst would be stored as earlier read bytes still
// wait in the byte store. A stalled result side holds the back and so the command queue.
module burst_ring_buffer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [brb_pkg::OP_W-1:0]     opcode,
	input  logic [brb_pkg::BURST_W-1:0]  burst_count,
	input  logic [brb_pkg::DATA_W-1:0]   data_in,
	input  logic                         flush_on_short,
	output logic                         empty,
	input  logic                         pop,
	output logic [brb_pkg::STATUS_W-1:0] status,
	output logic [brb_pkg::DATA_W-1:0]   data_out,
	output logic                         data_valid,
	output logic                         last,
	input  logic                         cfg_we,
	input  logic [brb_pkg::CAP_W-1:0]    cfg_wdata
);

	logic [brb_pkg::CNT_W-1:0]  cap;
	brb_pkg::mem_wr_t           mem_wr;
	logic                       cmd_push;
	brb_pkg::cmd_t              cmd;
	logic                       cmdq_full;
	brb_pkg::cmd_t              head;
	logic                       head_empty;
	logic                       head_pop;
	logic                       ram_re;
	logic [brb_pkg::IDX_W-1:0]  ram_raddr;
	logic [brb_pkg::DATA_W-1:0] ram_rdata;

	brb_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.opcode         (opcode),
		.burst_count    (burst_count),
		.data_in        (data_in),
		.flush_on_short (flush_on_short),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.cap            (cap),
		.mem_wr         (mem_wr),
		.cmd_push       (cmd_push),
		.cmd            (cmd),
		.cmdq_full      (cmdq_full),
		.rd_beat        (ram_re)
	);

	brb_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd),
		.full   (cmdq_full),
		.pop    (head_pop),
		.dout   (head),
		.empty  (head_empty)
	);

	brb_ram #(
		.WIDTH (brb_pkg::DATA_W),
		.DEPTH (brb_pkg::RING_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_wr.en),
		.waddr (mem_wr.addr),
		.wdata (mem_wr.data),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	brb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cap        (cap),
		.head       (head),
		.head_valid (!head_empty),
		.head_pop   (head_pop),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.empty      (empty),
		.pop        (pop),
		.status     (status),
		.data_out   (data_out),
		.data_valid (data_valid),
		.last       (last)
	);

endmodule

@@ design/brb_checker.sv @@
// Port-level checks of the burst ring buffer and their binding
`include "assert_macros.svh"

module brb_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         full,
	input logic                         empty,
	input logic                         pop,
	input logic [brb_pkg::STATUS_W-1:0] status,
	input logic [brb_pkg::DATA_W-1:0]   data_out,
	input logic                         data_valid,
	input logic                         last
);

	// reset leaves no result waiting and the input side open
	`BRB_ASSERT_ALWAYS(a_reset_clear, !arst_n |=> empty && !full)

	// read bytes only come from a successful read
	`BRB_ASSERT(a_data_ok, !empty && data_valid |-> status == brb_pkg::ST_OK)

	// results without a byte are single beats with a zero byte field
	`BRB_ASSERT(a_nodata_last, !empty && !data_valid |-> last && data_out == '0)

	// a waiting result holds until taken
	`BRB_ASSERT(a_hold, !empty && !pop |=> !empty && $stable({status, data_out, data_valid, last}))

endmodule

bind burst_ring_buffer brb_checker u_brb_checker (.*);

@@ dv/burst_ring_buffer_tb.sv @@
// Self-checking testbench for the burst ring buffer: directed cases, then random traffic
module burst_ring_buffer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int OpW     = brb_pkg::OP_W;
	localparam int BurstW  = brb_pkg::BURST_W;
	localparam int DataW   = brb_pkg::DATA_W;
	localparam int StatusW = brb_pkg::STATUS_W;
	localparam int CapW    = brb_pkg::CAP_W;

	localparam logic [OpW-1:0] OP_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 12;
	localparam int MAX_REPORTS   = 10;

	logic                clk;
	logic                arst_n         = 1'b0;
	logic                push           = 1'b0;
	logic                full;
	logic [OpW-1:0]      opcode         = brb_pkg::OP_HDR;
	logic [BurstW-1:0]   burst_count    = '0;
	logic [DataW-1:0]    data_in        = '0;
	logic                flush_on_short = 1'b0;
	logic                empty;
	logic                pop            = 1'b0;
	logic [StatusW-1:0]  status;
	logic [DataW-1:0]    data_out;
	logic                data_valid;
	logic                last;
	logic                cfg_we         = 1'b0;
	logic [CapW-1:0]     cfg_wdata      = '0;

	// Shadow of the ring and its pointers, advanced on every accepted beat
	logic [DataW-1:0] shadow_bytes [brb_pkg::RING_DEPTH];
	int unsigned shadow_rd    = 0;
	int unsigned shadow_wr    = 0;
	int unsigned shadow_fill  = 0;
	int unsigned shadow_left  = 0;
	bit          shadow_admit = 1'b0;
	int unsigned shadow_cap   = brb_pkg::RING_DEPTH;

	brb_pkg::res_t pending_results [$];

	int unsigned items_sent    = 0;
	int unsigned results_seen  = 0;
	int unsigned cap_writes    = 0;
	int unsigned error_count   = 0;
	int unsigned tx_run_left   = 0;
	int unsigned rx_mode       = 0;
	int unsigned rx_hold       = 0;
	int unsigned rx_phase      = 0;

	burst_ring_buffer u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.opcode         (opcode),
		.burst_count    (burst_count),
		.data_in        (data_in),
		.flush_on_short (flush_on_short),
		.empty          (empty),
		.pop            (pop),
		.status         (status),
		.data_out       (data_out),
		.data_valid     (data_valid),
		.last           (last),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("timeout with %0d results still outstanding", pending_results.size());
		$display("[burst_ring_buffer] ERROR");
		$finish;
	end

	function void flag_error(string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endfunction

	function int unsigned ring_next(int unsigned idx);
		return (idx + 1 >= shadow_cap) ? 0 : idx + 1;
	endfunction

	// Work out the results of one accepted beat and queue them
	function void ring_predict(logic [OpW-1:0] op, logic [BurstW-1:0] cnt,
			logic [DataW-1:0] d, logic fl);
		int unsigned n;
		int unsigned space;
		int unsigned k;
		brb_pkg::res_t r;
		n = (cnt > brb_pkg::MAX_BURST) ? brb_pkg::MAX_BURST : cnt;
		r = '0;
		r.last = 1'b1;
		case (op)
			brb_pkg::OP_HDR: begin
				space = (shadow_fill >= shadow_cap) ? 0 : shadow_cap - shadow_fill;
				shadow_left = n;
				if (space >= n) begin
					shadow_admit = 1'b1;
					r.status = (2 * (shadow_fill + n) > shadow_cap) ?
						brb_pkg::ST_HALF : brb_pkg::ST_OK;
				end else begin
					shadow_admit = 1'b0;
					r.status = brb_pkg::ST_NOROOM;
				end
				pending_results.push_back(r);
			end
			brb_pkg::OP_DATA: begin
				if (shadow_left > 0) begin
					if (shadow_admit && shadow_fill < shadow_cap) begin
						shadow_bytes[shadow_wr % brb_pkg::RING_DEPTH] = d;
						shadow_wr = ring_next(shadow_wr);
						shadow_fill++;
					end
					shadow_left--;
				end
			end
			brb_pkg::OP_READ: begin
				if (shadow_fill >= n) begin
					if (n == 0) begin
						r.status = brb_pkg::ST_OK;
						pending_results.push_back(r);
					end else begin
						for (k = 0; k < n; k++) begin
							r.status = brb_pkg::ST_OK;
							r.data   = shadow_bytes[shadow_rd % brb_pkg::RING_DEPTH];
							r.valid  = 1'b1;
							r.last   = (k + 1 == n);
							pending_results.push_back(r);
							shadow_rd = ring_next(shadow_rd);
						end
						shadow_fill -= n;
					end
				end else begin
					r.status = (shadow_fill == 0) ? brb_pkg::ST_EMPTY : brb_pkg::ST_SHORT;
					pending_results.push_back(r);
					if (fl) begin
						shadow_rd   = 0;
						shadow_wr   = 0;
						shadow_fill = 0;
					end
				end
			end
			default: ;
		endcase
	endfunction

	// Offer one beat, hold it until taken, then maybe idle between bursts
	task automatic send_item(logic [OpW-1:0] op, logic [BurstW-1:0] cnt,
			logic [DataW-1:0] d, logic fl);
		int unsigned gap;
		push           <= 1'b1;
		opcode         <= op;
		burst_count    <= cnt;
		data_in        <= d;
		flush_on_short <= fl;
		@(posedge clk);
		while (full)
			@(posedge clk);
		ring_predict(op, cnt, d, fl);
		items_sent++;
		if (tx_run_left > 0)
			tx_run_left--;
		if (tx_run_left == 0) begin
			tx_run_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic write_burst(int unsigned n, int unsigned k);
		send_item(brb_pkg::OP_HDR, BurstW'(n), DataW'($urandom), 1'($urandom_range(0, 1)));
		repeat (k)
			send_item(brb_pkg::OP_DATA, BurstW'($urandom), DataW'($urandom),
				1'($urandom_range(0, 1)));
	endtask

	task automatic read_bytes(int unsigned n, logic fl);
		send_item(brb_pkg::OP_READ, BurstW'(n), DataW'($urandom), fl);
	endtask

	// Stop sending and hold until every queued result has been taken
	task automatic wait_drained();
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(logic [CapW-1:0] v);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_cap = (v == 0) ? 1 :
			((v > brb_pkg::RING_DEPTH) ? brb_pkg::RING_DEPTH : v);
		cap_writes++;
	endtask

	// Close any open burst, read the ring down and flush so both pointers sit at zero
	task automatic drain_ring();
		send_item(brb_pkg::OP_HDR, '0, DataW'($urandom), 1'b0);
		while (shadow_fill >= brb_pkg::MAX_BURST)
			read_bytes(brb_pkg::MAX_BURST, 1'b0);
		read_bytes(shadow_fill + 1, 1'b1);
	endtask

	task automatic test_idle_ring();
		read_bytes(5, 1'b0);
		read_bytes(0, 1'b0);
		send_item(brb_pkg::OP_DATA, BurstW'($urandom), 8'hA5, 1'b0);
		send_item(OP_SPARE, 7'h7F, 8'hFF, 1'b1);
		read_bytes(1, 1'b1);
	endtask

	task automatic test_full_burst();
		int unsigned i;
		send_item(brb_pkg::OP_HDR, BurstW'(brb_pkg::MAX_BURST), 8'h00, 1'b0);
		for (i = 0; i < brb_pkg::MAX_BURST; i++)
			send_item(brb_pkg::OP_DATA, BurstW'($urandom),
				(i == 0) ? 8'h00 : (i == brb_pkg::MAX_BURST - 1) ? 8'hFF : DataW'($urandom),
				1'b0);
		// oversized count saturates to a full burst
		read_bytes(7'h7F, 1'b1);
	endtask

	task automatic test_refusal();
		set_capacity(CapW'(16));
		write_burst(10, 10);
		write_burst(7, 7);
		read_bytes(12, 1'b0);
		read_bytes(4, 1'b0);
		read_bytes(12, 1'b1);
		read_bytes(1, 1'b0);
		// a new header abandons the open burst
		write_burst(4, 1);
		write_burst(3, 3);
		read_bytes(4, 1'b0);
		// an open burst survives a flush and resumes at slot zero
		write_burst(4, 2);
		read_bytes(9, 1'b1);
		repeat (2) send_item(brb_pkg::OP_DATA, BurstW'($urandom), DataW'($urandom), 1'b0);
		read_bytes(2, 1'b0);
	endtask

	task automatic test_capacity_extremes();
		set_capacity('0);
		write_burst(1, 1);
		send_item(brb_pkg::OP_HDR, BurstW'(1), DataW'($urandom), 1'b0);
		read_bytes(1, 1'b0);
		write_burst(1, 1);
		read_bytes(2, 1'b1);
		read_bytes(1, 1'b0);
		set_capacity(13'h1FFF);
	endtask

	task automatic test_capacity_shrink();
		drain_ring();
		set_capacity(CapW'(brb_pkg::RING_DEPTH));
		write_burst(20, 20);
		write_burst(10, 2);
		// ring now holds more than the new capacity: drop the rest of the burst
		set_capacity(CapW'(8));
		repeat (8) send_item(brb_pkg::OP_DATA, BurstW'($urandom), DataW'($urandom), 1'b0);
		send_item(brb_pkg::OP_HDR, BurstW'(2), DataW'($urandom), 1'b0);
		read_bytes(8, 1'b0);
		send_item(brb_pkg::OP_HDR, BurstW'(2), DataW'($urandom), 1'b0);
		read_bytes(8, 1'b0);
		// write pointer beyond capacity wraps on its next advance
		write_burst(2, 2);
		read_bytes(8, 1'b0);
		drain_ring();
	endtask

	task automatic random_phase(logic [CapW-1:0] cap, int unsigned quota);
		int unsigned counted;
		int unsigned lim;
		int unsigned n;
		int unsigned k;
		int unsigned pick;
		drain_ring();
		set_capacity(cap);
		lim = (shadow_cap < brb_pkg::MAX_BURST) ? shadow_cap : brb_pkg::MAX_BURST;
		counted = 0;
		while (counted < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				case ($urandom_range(0, 9))
					0:       n = $urandom_range(brb_pkg::MAX_BURST + 1, 127);
					1:       n = $urandom_range(0, brb_pkg::MAX_BURST);
					default: n = $urandom_range(0, lim);
				endcase
				k = (n > brb_pkg::MAX_BURST) ? brb_pkg::MAX_BURST : n;
				case ($urandom_range(0, 9))
					0:       k = $urandom_range(0, k);
					1:       k = k + $urandom_range(1, 3);
					default: ;
				endcase
				write_burst(n, k);
				counted += 1 + k;
			end else if (pick < 85) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5:
						n = $urandom_range(0, (shadow_fill < brb_pkg::MAX_BURST) ?
							shadow_fill : brb_pkg::MAX_BURST);
					9:       n = $urandom_range(brb_pkg::MAX_BURST + 1, 127);
					default: n = $urandom_range(0, brb_pkg::MAX_BURST);
				endcase
				read_bytes(n, $urandom_range(0, 3) == 0);
				counted++;
			end else if (pick < 92) begin
				send_item(brb_pkg::OP_DATA, BurstW'($urandom), DataW'($urandom),
					1'($urandom_range(0, 1)));
			end else if (pick < 96) begin
				send_item(OP_SPARE, BurstW'($urandom), DataW'($urandom),
					1'($urandom_range(0, 1)));
			end else begin
				wait_drained();
			end
		end
	endtask

	task automatic test_random_traffic();
		random_phase(CapW'(brb_pkg::RING_DEPTH), 30);
		random_phase(CapW'(1), 20);
		random_phase(CapW'(37), 30);
		random_phase(CapW'(16), 30);
		random_phase(CapW'(300), 30);
		random_phase(CapW'(5), 20);
		random_phase(CapW'(100), 30);
		random_phase(CapW'(brb_pkg::RING_DEPTH), 30);
	endtask

	// Take results on a changing stall pattern and compare each with the oldest expectation
	always @(posedge clk) begin : result_check
		brb_pkg::res_t got;
		brb_pkg::res_t want;
		if (arst_n && pop && !empty) begin
			got = {status, data_out, data_valid, last};
			results_seen++;
			if (pending_results.size() == 0) begin
				flag_error($sformatf("unexpected result: status %0d data %02h valid %0b last %0b",
					got.status, got.data, got.valid, got.last));
			end else begin
				want = pending_results.pop_front();
				if (got !== want)
					flag_error($sformatf({"mismatch: expected status %0d data %02h valid %0b ",
						"last %0b, got status %0d data %02h valid %0b last %0b"},
						want.status, want.data, want.valid, want.last,
						got.status, got.data, got.valid, got.last));
			end
		end
		if (rx_hold == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_hold = $urandom_range(50, 300);
		end else begin
			rx_hold--;
		end
		rx_phase = (rx_phase + 1) % 19;
		case (rx_mode)
			0:       pop <= 1'b1;
			1:       pop <= 1'($urandom_range(0, 1));
			default: pop <= (rx_phase < 3);
		endcase
	end

	initial begin : run_tests
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_ring();
		test_full_burst();
		test_refusal();
		test_capacity_extremes();
		test_capacity_shrink();
		test_random_traffic();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			flag_error($sformatf("%0d expected results never arrived", pending_results.size()));
		$display("run covered %0d beats in, %0d results out, %0d capacity writes",
			items_sent, results_seen, cap_writes);
		$display({"bursts admitted, refused and abandoned, short and empty reads, flushes, ",
			"capacities 1 to 4096; %0d failures"}, error_count);
		if (error_count == 0)
			$display("[burst_ring_buffer] OK");
		else
			$display("[burst_ring_buffer] ERROR");
		$finish;
	end

endmodule

@@ burst_ring_buffer.f @@
+incdir+design
design/brb_pkg.sv
design/brb_ram.sv
design/brb_cmdq.sv
design/brb_front.sv
design/brb_back.sv
design/burst_ring_buffer.sv
design/brb_checker.sv
dv/burst_ring_buffer_tb.sv
